@@ hdl/ccws_pkg.sv @@
`timescale 1ns / 1ps
// Shared character codes and the record type passed from front to back.
package ccws_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;

    localparam int REC_MAX = 3;

    typedef struct packed {
        logic [REC_MAX-1:0][7:0] bytes;
        logic [1:0]              cnt;
        logic                    bare;
        logic                    last;
    } rec_t;

endpackage

@@ hdl/ccws_front.sv @@
`timescale 1ns / 1ps
// Front end: block and line comment passes plus whitespace filter, one byte per beat.
module ccws_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [7:0]     in_byte,
    input  logic           in_last,
    input  logic           fifo_full,
    output ccws_pkg::rec_t rec,
    output logic           rec_valid
);
    import ccws_pkg::*;

    typedef enum logic [1:0] {
        B_NORMAL = 2'd0,
        B_HELD   = 2'd1,
        B_IN     = 2'd2,
        B_STAR   = 2'd3
    } block_mode_t;

    typedef enum logic [1:0] {
        L_NORMAL = 2'd0,
        L_HELD   = 2'd1,
        L_IN     = 2'd2
    } line_mode_t;

    typedef struct packed {
        logic [3:0][7:0] b;
        logic [2:0]      n;
    } keep_t;

    typedef struct packed {
        line_mode_t mode;
        keep_t      k;
    } line_res_t;

    function automatic keep_t add_char(keep_t k, logic [7:0] ch);
        keep_t r;
        r = k;
        if (ch != CH_TAB && ch != CH_CR && ch != CH_LF && r.n < 3'd4)
        begin
            r.b[r.n[1:0]] = ch;
            r.n = r.n + 3'd1;
        end
        return r;
    endfunction

    function automatic line_res_t line_step(line_mode_t m, keep_t k, logic [7:0] ch);
        line_res_t r;
        r.mode = m;
        r.k    = k;
        case (m)
            L_HELD:
            begin
                if (ch == CH_SLASH)
                begin
                    r.mode = L_IN;
                end
                else
                begin
                    r.mode = L_NORMAL;
                    r.k    = add_char(r.k, CH_SLASH);
                    r.k    = add_char(r.k, ch);
                end
            end
            L_IN:
            begin
                if (ch == CH_CR || ch == CH_LF)
                begin
                    r.mode = L_NORMAL;
                    r.k    = add_char(r.k, ch);
                end
            end
            default:
            begin
                r.mode = L_NORMAL;
                if (ch == CH_SLASH)
                    r.mode = L_HELD;
                else
                    r.k = add_char(r.k, ch);
            end
        endcase
        return r;
    endfunction

    block_mode_t block_mode_reg, block_mode_next;
    line_mode_t  line_mode_reg,  line_mode_next;
    logic        accept;

    always_comb
    begin
        block_mode_t     bm;
        line_mode_t      lm;
        logic [2:0][7:0] lch;
        logic [1:0]      ln;
        keep_t           kp;
        line_res_t       lr;

        accept = push && !fifo_full;
        bm     = block_mode_reg;
        lm     = line_mode_reg;
        lch    = '0;
        ln     = 2'd0;
        kp     = '0;

        case (block_mode_reg)
            B_HELD:
            begin
                if (in_byte == CH_STAR)
                begin
                    bm = B_IN;
                end
                else if (in_byte == CH_SLASH)
                begin
                    lch[0] = CH_SLASH;
                    ln     = 2'd1;
                end
                else
                begin
                    bm     = B_NORMAL;
                    lch[0] = CH_SLASH;
                    lch[1] = in_byte;
                    ln     = 2'd2;
                end
            end
            B_IN:
            begin
                if (in_byte == CH_STAR)
                    bm = B_STAR;
            end
            B_STAR:
            begin
                if (in_byte == CH_SLASH)
                    bm = B_NORMAL;
                else if (in_byte != CH_STAR)
                    bm = B_IN;
            end
            default:
            begin
                if (in_byte == CH_SLASH)
                begin
                    bm = B_HELD;
                end
                else
                begin
                    lch[0] = in_byte;
                    ln     = 2'd1;
                end
            end
        endcase

        // release a slash still held by the block pass at the end of the text
        if (in_last && bm == B_HELD)
        begin
            lch[ln] = CH_SLASH;
            ln      = ln + 2'd1;
        end

        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < ln)
            begin
                lr = line_step(lm, kp, lch[i]);
                lm = lr.mode;
                kp = lr.k;
            end
        end

        if (in_last && lm == L_HELD)
            kp = add_char(kp, CH_SLASH);

        if (in_last)
        begin
            bm = B_NORMAL;
            lm = L_NORMAL;
        end

        rec.bytes = kp.b[2:0];
        rec.cnt   = (kp.n > 3'd3) ? 2'd3 : kp.n[1:0];
        rec.bare  = 1'b0;
        rec.last  = in_last;
        if (in_last && kp.n == 3'd0)
        begin
            rec.bytes = '0;
            rec.cnt   = 2'd1;
            rec.bare  = 1'b1;
        end

        rec_valid       = accept && (rec.cnt != 2'd0);
        block_mode_next = bm;
        line_mode_next  = lm;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_mode_reg <= B_NORMAL;
            line_mode_reg  <= L_NORMAL;
        end
        else if (accept)
        begin
            block_mode_reg <= block_mode_next;
            line_mode_reg  <= line_mode_next;
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid |-> !fifo_full)
        else $error("record written while queue full");

    a_last_empties_modes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |=> (block_mode_reg == B_NORMAL && line_mode_reg == L_NORMAL))
        else $error("modes not cleared after end of text");

    a_last_gives_record: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_last) |-> rec_valid)
        else $error("end of text produced no record");

endmodule

@@ hdl/ccws_fifo.sv @@
`timescale 1ns / 1ps
// Short record queue between front and back.
module ccws_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  ccws_pkg::rec_t wr_data,
    input  logic           rd_en,
    output ccws_pkg::rec_t rd_data,
    output logic           full,
    output logic           empty
);
    import ccws_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rec_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CW'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && full) |-> rd_en)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> !empty)
        else $error("queue underflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

@@ hdl/ccws_back.sv @@
`timescale 1ns / 1ps
// Back end: unpacks each record into result beats, one per pop.
module ccws_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  ccws_pkg::rec_t fifo_data,
    input  logic           fifo_empty,
    output logic           fifo_rd,
    input  logic           pop,
    output logic           empty,
    output logic [7:0]     out_byte,
    output logic           has_byte,
    output logic           out_last
);
    import ccws_pkg::*;

    rec_t       cur_reg,   cur_next;
    logic       valid_reg, valid_next;
    logic [1:0] idx_reg,   idx_next;
    logic       take;
    logic       at_end;
    logic       done;

    assign empty    = !valid_reg;
    assign at_end   = (idx_reg == cur_reg.cnt - 2'd1);
    assign out_byte = cur_reg.bytes[idx_reg];
    assign has_byte = !cur_reg.bare;
    assign out_last = cur_reg.last && at_end;

    always_comb
    begin
        take       = valid_reg && pop;
        done       = take && at_end;
        fifo_rd    = (!valid_reg || done) && !fifo_empty;
        cur_next   = cur_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (fifo_rd)
        begin
            cur_next   = fifo_data;
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (done)
        begin
            valid_next = 1'b0;
        end
        else if (take)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (cur_reg.cnt != 2'd0 && idx_reg < cur_reg.cnt))
        else $error("beat index beyond record");

    a_bare_is_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && cur_reg.bare) |-> (cur_reg.last && cur_reg.cnt == 2'd1))
        else $error("bare marker not a lone final beat");

    a_held_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !pop) |=> (valid_reg && $stable(idx_reg)))
        else $error("result advanced without pop");

endmodule

@@ hdl/c_comment_and_whitespace_stripper.sv @@
`timescale 1ns / 1ps
// Top level: C comment and whitespace stripper with queue ports on both sides.
// Path: an accepted byte's record is written into the record queue and then loaded into the
// result stage, which drives the result outputs.
// Throughput: one byte per cycle while each byte yields at most one result and pop stays high;
// a byte yielding k results holds the single result port of the back end for k pops,
// and the record queue of DEPTH entries absorbs the difference.
// Reset: asynchronous, clears both comment pass modes, the queue and the result stage.
module c_comment_and_whitespace_stripper
#(
    parameter int DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       out_last
);
    import ccws_pkg::*;

    rec_t front_rec;
    logic front_valid;
    rec_t fifo_data;
    logic fifo_empty;
    logic fifo_rd;

    ccws_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .fifo_full (full),
        .rec       (front_rec),
        .rec_valid (front_valid)
    );

    ccws_fifo #(.DEPTH(DEPTH)) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_valid),
        .wr_data (front_rec),
        .rd_en   (fifo_rd),
        .rd_data (fifo_data),
        .full    (full),
        .empty   (fifo_empty)
    );

    ccws_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_data  (fifo_data),
        .fifo_empty (fifo_empty),
        .fifo_rd    (fifo_rd),
        .pop        (pop),
        .empty      (empty),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .out_last   (out_last)
    );

endmodule

@@ tb/c_comment_and_whitespace_stripper_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the C comment and whitespace stripper: directed and random texts, scoreboard.
module c_comment_and_whitespace_stripper_tb;

    import ccws_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_ITEMS  = 40;
    localparam int RANDOM_ITEMS = 385;

    typedef enum logic [1:0] {MODE_NORMAL, MODE_HELD, MODE_IN, MODE_STAR} pass_mode_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } text_beat_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       fin;
    } stripped_beat_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       in_last;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    text_beat_t     pending_q[$];
    stripped_beat_t stripped_q[$];
    logic [7:0]     kept_q[$];

    pass_mode_e block_mode = MODE_NORMAL;
    pass_mode_e line_mode  = MODE_NORMAL;

    text_beat_t     next_beat;
    stripped_beat_t want;
    logic           in_taken = 1'b0;
    int             send_gap = 0;
    int             recv_gap = 0;
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;
    int             cycle_count = 0;
    int             error_count = 0;

    c_comment_and_whitespace_stripper u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .has_byte (has_byte),
        .out_last (out_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void keep_char(logic [7:0] c);
        if (c != CH_TAB && c != CH_CR && c != CH_LF)
            kept_q.push_back(c);
    endfunction

    function automatic void line_filter(logic [7:0] c);
        case (line_mode)
            MODE_HELD:
            begin
                if (c == CH_SLASH)
                    line_mode = MODE_IN;
                else
                begin
                    line_mode = MODE_NORMAL;
                    keep_char(CH_SLASH);
                    keep_char(c);
                end
            end
            MODE_IN:
            begin
                if (c == CH_CR || c == CH_LF)
                begin
                    line_mode = MODE_NORMAL;
                    keep_char(c);
                end
            end
            default:
            begin
                line_mode = MODE_NORMAL;
                if (c == CH_SLASH)
                    line_mode = MODE_HELD;
                else
                    keep_char(c);
            end
        endcase
    endfunction

    function automatic void block_filter(logic [7:0] c);
        case (block_mode)
            MODE_HELD:
            begin
                if (c == CH_STAR)
                    block_mode = MODE_IN;
                else if (c == CH_SLASH)
                    line_filter(CH_SLASH);
                else
                begin
                    block_mode = MODE_NORMAL;
                    line_filter(CH_SLASH);
                    line_filter(c);
                end
            end
            MODE_IN:
            begin
                if (c == CH_STAR)
                    block_mode = MODE_STAR;
            end
            MODE_STAR:
            begin
                if (c == CH_SLASH)
                    block_mode = MODE_NORMAL;
                else if (c != CH_STAR)
                    block_mode = MODE_IN;
            end
            default:
            begin
                if (c == CH_SLASH)
                    block_mode = MODE_HELD;
                else
                    line_filter(c);
            end
        endcase
    endfunction

    function automatic void strip_byte(logic [7:0] c, logic fin);
        stripped_beat_t r;
        int n;
        kept_q.delete();
        block_filter(c);
        if (fin)
        begin
            if (block_mode == MODE_HELD)
                line_filter(CH_SLASH);
            if (line_mode == MODE_HELD)
                keep_char(CH_SLASH);
            block_mode = MODE_NORMAL;
            line_mode  = MODE_NORMAL;
        end
        n = (kept_q.size() > REC_MAX) ? REC_MAX : kept_q.size();
        for (int k = 0; k < n; k++)
        begin
            r.ch  = kept_q[k];
            r.has = 1'b1;
            r.fin = fin && (k == n - 1);
            stripped_q.push_back(r);
        end
        if (fin && n == 0)
        begin
            r.ch  = 8'h00;
            r.has = 1'b0;
            r.fin = 1'b1;
            stripped_q.push_back(r);
        end
    endfunction

    function automatic void add_beat(logic [7:0] c, logic fin);
        text_beat_t b;
        b.ch  = c;
        b.fin = fin;
        pending_q.push_back(b);
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_beat(s[i], i == s.len() - 1);
    endfunction

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0, 1, 2, 3: return CH_SLASH;
            4, 5:       return CH_STAR;
            6:          return CH_LF;
            7:          return CH_CR;
            8:          return CH_TAB;
            14, 15:     return 8'($urandom_range(0, 255));
            default:    return 8'($urandom_range(8'h61, 8'h7A));
        endcase
    endfunction

    function automatic void add_random_text();
        logic [7:0] txt[$];
        int ntok;
        int len;
        bit tidy;
        ntok = $urandom_range(1, 6);
        tidy = ($urandom_range(0, 3) != 0);
        for (int t = 0; t < ntok; t++)
        begin
            len = $urandom_range(0, 4);
            if (!tidy)
            begin
                for (int i = 0; i <= len; i++)
                    txt.push_back(pick_char());
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        for (int i = 0; i <= len; i++)
                            txt.push_back(8'($urandom_range(8'h21, 8'h7E)));
                    end
                    1:
                    begin
                        txt.push_back(CH_SLASH);
                        txt.push_back(CH_STAR);
                        for (int i = 0; i < len; i++)
                            txt.push_back(pick_char());
                        txt.push_back(CH_STAR);
                        txt.push_back(CH_SLASH);
                    end
                    2:
                    begin
                        txt.push_back(CH_SLASH);
                        txt.push_back(CH_SLASH);
                        for (int i = 0; i < len; i++)
                            txt.push_back(pick_char());
                        txt.push_back($urandom_range(0, 1) ? CH_LF : CH_CR);
                    end
                    3:
                    begin
                        for (int i = 0; i <= len; i++)
                        begin
                            case ($urandom_range(0, 2))
                                0:       txt.push_back(CH_TAB);
                                1:       txt.push_back(CH_CR);
                                default: txt.push_back(CH_LF);
                            endcase
                        end
                    end
                    default:
                        txt.push_back(pick_char());
                endcase
            end
        end
        for (int i = 0; i < txt.size(); i++)
            add_beat(txt[i], i == txt.size() - 1);
    endfunction

    always @(posedge clk)
    begin
        in_taken <= rst_n && push && !full;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (stripped_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display("unexpected beat: byte %02h has %0b last %0b",
                                 out_byte, has_byte, out_last);
                end
                else
                begin
                    want = stripped_q.pop_front();
                    if (out_byte !== want.ch || has_byte !== want.has
                        || out_last !== want.fin)
                    begin
                        error_count++;
                        if (error_count <= 10)
                            $display("mismatch: want %02h/%0b/%0b got %02h/%0b/%0b",
                                     want.ch, want.has, want.fin,
                                     out_byte, has_byte, out_last);
                    end
                end
            end
            if (push && !full)
                strip_byte(in_byte, in_last);
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else if (!push || in_taken)
        begin
            if (send_gap > 0)
            begin
                push     <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_q.size() == 0)
                push <= 1'b0;
            else if (pending_q.size() > QUIET_ITEMS
                     && $urandom_range(0, 99) < send_idle_pct)
            begin
                push     <= 1'b0;
                send_gap <= $urandom_range(0, 9);
            end
            else
            begin
                next_beat = pending_q.pop_front();
                push    <= 1'b1;
                in_byte <= next_beat.ch;
                in_last <= next_beat.fin;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (recv_gap > 0)
        begin
            pop      <= 1'b0;
            recv_gap <= recv_gap - 1;
        end
        else if (pending_q.size() > QUIET_ITEMS && $urandom_range(0, 99) < recv_stall_pct)
        begin
            pop      <= 1'b0;
            recv_gap <= $urandom_range(0, 9);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 256 == 0)
        begin
            send_idle_pct  <= $urandom_range(0, 3) * 10;
            recv_stall_pct <= $urandom_range(0, 3) * 10;
        end
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int random_start;
        rst_n   = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        in_byte = 8'h00;
        in_last = 1'b0;

        add_text("/*/*/");
        add_text("//**/y");
        add_text("x/*a");
        add_text("\t//\015q");
        add_text("k/");
        add_text("\377//");
        add_beat(8'h00, 1'b0);
        add_beat(CH_LF, 1'b1);
        random_start = pending_q.size();
        while (pending_q.size() - random_start < RANDOM_ITEMS)
            add_random_text();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || push)
            @(posedge clk);
        while (stripped_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (error_count == 0 && stripped_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
